// ===== src/channel_length_frame_deframer_assert.svh =====
// assertion macros shared by the deframer modules
`ifndef CHANNEL_LENGTH_FRAME_DEFRAMER_ASSERT_SVH
`define CHANNEL_LENGTH_FRAME_DEFRAMER_ASSERT_SVH

`ifndef ASSERT_OFF
// checked on every rising edge, skipped while reset is held
`define CLFD_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// checked on every rising edge, reset included
`define CLFD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CLFD_ASSERT(lbl, clk, rstn, prop, msg)
`define CLFD_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== src/clfd_pkg.sv =====
// shared types and constants of the channel length frame deframer
`default_nettype none

package clfd_pkg;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned LenW      = 32;
  localparam int unsigned CfgIdxW   = 8;
  localparam int unsigned CfgDataW  = 64;
  localparam int unsigned NumCfgReg = 4;
  localparam int unsigned MaskW     = NumCfgReg * CfgDataW;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_EN0 = 8'd0;
  localparam logic [CfgIdxW-1:0] REG_EN1 = 8'd1;
  localparam logic [CfgIdxW-1:0] REG_EN2 = 8'd2;
  localparam logic [CfgIdxW-1:0] REG_EN3 = 8'd3;

  typedef struct packed {
    logic [ByteW-1:0] channel;
    logic [ByteW-1:0] data;
    logic             last;
    logic             empty;
  } result_t;

  // flow control between the parser and the output stage
  typedef struct packed {
    logic take;      // parser hands over a result this cycle
    logic can_take;  // output stage is free or being drained
  } flow_t;

endpackage

`default_nettype wire

// ===== src/channel_length_frame_deframer.sv =====
// Channel length frame deframer, top level.
// A byte stream enters on the in channel (valid/ready, one byte per beat).
// Frames are a channel byte, LENGTH_BYTES little-endian length bytes, then
// the payload. Bytes that are not an enabled channel number are skipped
// while hunting. Each payload byte leaves on the out channel tagged with its
// channel and a last flag; a zero-length frame gives one beat marked empty.
// The cfg channel writes the four 64-bit channel enable words (index 0..3,
// other indexes ignored); cfg_ready_o is always high. Write only when idle.
// A byte taken into the input register is parsed from there, and its result is
// loaded into the output register once the output stage can take it.
// Throughput: one byte per cycle while the output is not stalled, set by the
// single parse step between the input register and the output register.
// When the receiver stalls with a result pending, the input register fills
// and in_ready_o drops until the pending beat is taken.
// Reset clears the enable mask (all channels off), parse state and both
// valid flags; the block then hunts for a channel byte.
`default_nettype none

module channel_length_frame_deframer #(
  parameter int unsigned LENGTH_BYTES = 4
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_ready_o,
  input  wire  [7:0]  in_byte_i,
  output logic        out_valid_o,
  input  wire         out_ready_i,
  output logic [7:0]  frame_channel_o,
  output logic [7:0]  payload_byte_o,
  output logic        last_of_frame_o,
  output logic        empty_frame_o,
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire  [7:0]  cfg_index_i,
  input  wire  [63:0] cfg_data_i
);

  logic [clfd_pkg::MaskW-1:0] enable_mask;
  logic                       can_take;
  clfd_pkg::flow_t            flow;
  clfd_pkg::result_t          parse_res;
  clfd_pkg::result_t          out_res;

  clfd_cfg u_cfg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .enable_mask_o (enable_mask)
  );

  clfd_parser #(
    .LENGTH_BYTES (LENGTH_BYTES)
  ) u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .in_byte_i     (in_byte_i),
    .enable_mask_i (enable_mask),
    .can_take_i    (can_take),
    .flow_o        (flow),
    .result_o      (parse_res)
  );

  clfd_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .flow_i      (flow),
    .result_i    (parse_res),
    .can_take_o  (can_take),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .result_o    (out_res)
  );

  assign frame_channel_o = out_res.channel;
  assign payload_byte_o  = out_res.data;
  assign last_of_frame_o = out_res.last;
  assign empty_frame_o   = out_res.empty;

endmodule

`default_nettype wire

// ===== src/clfd_cfg.sv =====
// channel enable mask registers
`default_nettype none

module clfd_cfg (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire  [clfd_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  wire  [clfd_pkg::CfgDataW-1:0]      cfg_data_i,
  output logic [clfd_pkg::MaskW-1:0]         enable_mask_o
);

  logic [clfd_pkg::CfgDataW-1:0] en0_q, en1_q, en2_q, en3_q;
  logic                          wr_en;

  assign cfg_ready_o = 1'b1;
  assign wr_en       = cfg_valid_i & cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en0_q <= '0;
      en1_q <= '0;
      en2_q <= '0;
      en3_q <= '0;
    end else if (wr_en) begin
      // writes past the last register are dropped
      case (cfg_index_i)
        clfd_pkg::REG_EN0: en0_q <= cfg_data_i;
        clfd_pkg::REG_EN1: en1_q <= cfg_data_i;
        clfd_pkg::REG_EN2: en2_q <= cfg_data_i;
        clfd_pkg::REG_EN3: en3_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign enable_mask_o = {en3_q, en2_q, en1_q, en0_q};

endmodule

`default_nettype wire

// ===== src/clfd_parser.sv =====
// input register and per-byte frame parsing state
`default_nettype none

module clfd_parser #(
  parameter int unsigned LENGTH_BYTES = 4
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           in_valid_i,
  output logic                          in_ready_o,
  input  wire  [clfd_pkg::ByteW-1:0]    in_byte_i,
  input  wire  [clfd_pkg::MaskW-1:0]    enable_mask_i,
  input  wire                           can_take_i,
  output clfd_pkg::flow_t               flow_o,
  output clfd_pkg::result_t             result_o
);

  localparam int unsigned LidxW = (LENGTH_BYTES > 1) ? $clog2(LENGTH_BYTES) : 1;
  localparam logic [LidxW-1:0] LastLenIdx = LidxW'(LENGTH_BYTES - 1);

  localparam logic [1:0] PH_HUNT = 2'd0;
  localparam logic [1:0] PH_LEN  = 2'd1;
  localparam logic [1:0] PH_DATA = 2'd2;

  logic                        in_valid_q;
  logic [clfd_pkg::ByteW-1:0]  in_byte_q;
  logic                        advance;

  logic [1:0]                  phase_q, phase_d;
  logic [clfd_pkg::ByteW-1:0]  chan_q, chan_d;
  logic [clfd_pkg::LenW-1:0]   len_q, len_d;
  logic [LidxW-1:0]            len_idx_q, len_idx_d;
  logic [clfd_pkg::LenW-1:0]   data_idx_q, data_idx_d;

  logic [clfd_pkg::LenW-1:0]   len_merged;
  logic [clfd_pkg::LenW-1:0]   data_idx_inc;
  logic                        res_valid;
  clfd_pkg::result_t           res;

  assign advance    = in_valid_q & can_take_i;
  assign in_ready_o = ~in_valid_q | can_take_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_byte_q <= in_byte_i;
    end
  end

  // length bytes arrive little endian
  assign len_merged   = len_q | (clfd_pkg::LenW'(in_byte_q) << {len_idx_q, 3'b000});
  assign data_idx_inc = data_idx_q + 1'b1;

  always_comb begin
    phase_d    = phase_q;
    chan_d     = chan_q;
    len_d      = len_q;
    len_idx_d  = len_idx_q;
    data_idx_d = data_idx_q;
    res_valid  = 1'b0;
    res.channel = chan_q;
    res.data    = '0;
    res.last    = 1'b0;
    res.empty   = 1'b0;
    case (phase_q)
      PH_LEN: begin
        len_d     = len_merged;
        len_idx_d = len_idx_q + 1'b1;
        if (len_idx_q == LastLenIdx) begin
          len_idx_d = '0;
          if (len_merged == '0) begin
            phase_d   = PH_HUNT;
            res_valid = 1'b1;
            res.last  = 1'b1;
            res.empty = 1'b1;
          end else begin
            phase_d = PH_DATA;
          end
        end
      end
      PH_DATA: begin
        res_valid  = 1'b1;
        res.data   = in_byte_q;
        data_idx_d = data_idx_inc;
        if (data_idx_inc >= len_q) begin
          res.last   = 1'b1;
          data_idx_d = '0;
          phase_d    = PH_HUNT;
        end
      end
      default: begin
        phase_d = PH_HUNT;
        if (enable_mask_i[in_byte_q]) begin
          chan_d     = in_byte_q;
          len_d      = '0;
          len_idx_d  = '0;
          data_idx_d = '0;
          phase_d    = PH_LEN;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_HUNT;
      chan_q     <= '0;
      len_q      <= '0;
      len_idx_q  <= '0;
      data_idx_q <= '0;
    end else if (advance) begin
      phase_q    <= phase_d;
      chan_q     <= chan_d;
      len_q      <= len_d;
      len_idx_q  <= len_idx_d;
      data_idx_q <= data_idx_d;
    end
  end

  assign flow_o.take     = advance & res_valid;
  assign flow_o.can_take = can_take_i;
  assign result_o        = res;

`include "channel_length_frame_deframer_assert.svh"

  `CLFD_ASSERT(a_hunt_no_result, clk_i, rst_ni, (advance && phase_q == PH_HUNT) |-> !flow_o.take, "hunting byte produced a result")
  `CLFD_ASSERT(a_data_idx_bound, clk_i, rst_ni, (phase_q == PH_DATA) |-> (data_idx_q < len_q), "payload index past frame length")
  `CLFD_ASSERT(a_empty_is_last, clk_i, rst_ni, (flow_o.take && result_o.empty) |-> (result_o.last && result_o.data == '0), "empty frame result not final or nonzero")
  `CLFD_ASSERT(a_data_after_len, clk_i, rst_ni, (phase_q == PH_DATA && !$past(phase_q == PH_DATA)) |-> $past(phase_q == PH_LEN), "payload phase entered without length")

endmodule

`default_nettype wire

// ===== src/clfd_out.sv =====
// output result register
`default_nettype none

module clfd_out (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire clfd_pkg::flow_t          flow_i,
  input  wire clfd_pkg::result_t        result_i,
  output logic                          can_take_o,
  output logic                          out_valid_o,
  input  wire                           out_ready_i,
  output clfd_pkg::result_t             result_o
);

  logic              valid_q;
  clfd_pkg::result_t res_q;

  assign can_take_o = ~valid_q | out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (can_take_o) begin
      valid_q <= flow_i.take;
    end
  end

  always_ff @(posedge clk_i) begin
    if (flow_i.take) begin
      res_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = res_q;

`include "channel_length_frame_deframer_assert.svh"

  `CLFD_ASSERT(a_take_when_free, clk_i, rst_ni, flow_i.take |-> flow_i.can_take, "result handed over while output stalled")
  `CLFD_ASSERT(a_take_loads, clk_i, rst_ni, flow_i.take |=> out_valid_o, "handed result not held")
  `CLFD_ASSERT_ALWAYS(a_reset_empty, clk_i, !rst_ni |=> !valid_q, "output valid after reset edge")

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// self-checking testbench for the channel length frame deframer
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned LEN_BYTES       = 4;
  localparam int unsigned ITEMS_PER_PHASE = 425;
  localparam int unsigned NUM_PHASES      = 4;
  localparam int unsigned HOLD_CYCLES     = 300;
  localparam int unsigned DRAIN_CYCLES    = 4;
  localparam int unsigned NUM_RESET_ROWS  = 3;
  localparam int unsigned NUM_ROWS        = 22;
  localparam int unsigned MAX_REPORTS     = 50;

  // indexes past the enable words, writes there must be dropped
  localparam logic [clfd_pkg::CfgIdxW-1:0] REG_SPARE = 8'd4;
  localparam logic [clfd_pkg::CfgIdxW-1:0] REG_TOP   = 8'hFF;

  typedef enum logic [1:0] {
    SEEK_CHANNEL = 2'd0,
    TAKE_LENGTH  = 2'd1,
    TAKE_PAYLOAD = 2'd2
  } parse_phase_e;

  typedef struct {
    logic [7:0]        din;
    bit                typed;
    bit                has_beat;
    clfd_pkg::result_t beat;
  } stim_row_t;

  logic                          clk_i;
  logic                          rst_ni       = 1'b0;
  logic                          in_valid_i   = 1'b0;
  logic [7:0]                    in_byte_i    = 8'h00;
  logic                          out_ready_i  = 1'b0;
  logic                          cfg_valid_i  = 1'b0;
  logic [clfd_pkg::CfgIdxW-1:0]  cfg_index_i  = '0;
  logic [clfd_pkg::CfgDataW-1:0] cfg_data_i   = '0;
  logic                          in_ready_o;
  logic                          out_valid_o;
  logic [7:0]                    frame_channel_o;
  logic [7:0]                    payload_byte_o;
  logic                          last_of_frame_o;
  logic                          empty_frame_o;
  logic                          cfg_ready_o;

  // predictor state
  logic [clfd_pkg::MaskW-1:0] channel_mask = '0;
  parse_phase_e               parse_phase  = SEEK_CHANNEL;
  logic [7:0]                 frame_ch     = 8'h00;
  logic [31:0]                frame_len    = '0;
  logic [31:0]                byte_count   = '0;
  logic [31:0]                plan_len     = '0;

  clfd_pkg::result_t expected_beats[$];
  stim_row_t   directed_rows[NUM_ROWS];
  bit          row_typed = 1'b0;
  stim_row_t   cur_row;
  bit          hold_off_req = 1'b0;
  int unsigned burst_left = 0;
  int unsigned errors = 0;
  int unsigned frames_seen = 0;
  int unsigned empty_frames = 0;
  int unsigned beats_checked = 0;
  int unsigned bytes_skipped = 0;
  int unsigned hold_offs = 0;

  channel_length_frame_deframer #(
    .LENGTH_BYTES(LEN_BYTES)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .in_byte_i      (in_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .frame_channel_o(frame_channel_o),
    .payload_byte_o (payload_byte_o),
    .last_of_frame_o(last_of_frame_o),
    .empty_frame_o  (empty_frame_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #(5_000_000);
    $display("testbench: FAIL");
    $finish;
  end

  // one parse step on an accepted byte, returns 1 when a beat comes out
  function automatic bit advance_deframer(input logic [7:0] b,
                                          output clfd_pkg::result_t beat);
    beat = '0;
    case (parse_phase)
      TAKE_LENGTH: begin
        frame_len = frame_len | (32'(b) << (8 * byte_count[1:0]));
        byte_count++;
        if (byte_count >= LEN_BYTES) begin
          byte_count = '0;
          if (frame_len == 0) begin
            parse_phase = SEEK_CHANNEL;
            beat.channel = frame_ch;
            beat.data = 8'h00;
            beat.last = 1'b1;
            beat.empty = 1'b1;
            empty_frames++;
            return 1'b1;
          end
          parse_phase = TAKE_PAYLOAD;
        end
        return 1'b0;
      end
      TAKE_PAYLOAD: begin
        byte_count++;
        beat.channel = frame_ch;
        beat.data = b;
        beat.last = (byte_count >= frame_len);
        beat.empty = 1'b0;
        if (beat.last) begin
          byte_count = '0;
          parse_phase = SEEK_CHANNEL;
        end
        return 1'b1;
      end
      default: begin
        parse_phase = SEEK_CHANNEL;
        if (channel_mask[b]) begin
          frame_ch = b;
          frame_len = '0;
          byte_count = '0;
          parse_phase = TAKE_LENGTH;
          frames_seen++;
        end else begin
          bytes_skipped++;
        end
        return 1'b0;
      end
    endcase
  endfunction

  // next random byte, shaped by where the parser stands
  function automatic logic [7:0] pick_next_byte();
    logic [7:0] start;
    int unsigned roll;
    case (parse_phase)
      TAKE_LENGTH: begin
        if (byte_count == 0) begin
          roll = $urandom_range(0, 99);
          if (roll < 8) plan_len = '0;
          else if (roll < 96) plan_len = $urandom_range(1, 8);
          else plan_len = $urandom_range(9, 300);
        end
        return plan_len[8 * byte_count[1:0] +: 8];
      end
      TAKE_PAYLOAD: return 8'($urandom_range(0, 255));
      default: begin
        if ($urandom_range(0, 99) < 80) begin
          start = 8'($urandom_range(0, 255));
          for (int k = 0; k < 256; k++) begin
            if (channel_mask[8'(start + k)]) return 8'(start + k);
          end
        end
        // line noise, may or may not hit an enabled channel
        return 8'($urandom_range(0, 255));
      end
    endcase
  endfunction

  task automatic check_field(input string name, input logic [7:0] exp_v, input logic [7:0] act_v);
    if (exp_v !== act_v) begin
      if (errors < MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin : beat_monitor
    clfd_pkg::result_t want;
    clfd_pkg::result_t pred;
    bit                emits;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_beats.size() == 0) begin
          if (errors < MAX_REPORTS)
            $display("%0t: unexpected beat, expected none, got ch %0h data %0h last %0b empty %0b",
                     $time, frame_channel_o, payload_byte_o, last_of_frame_o, empty_frame_o);
          errors++;
        end else begin
          want = expected_beats.pop_front();
          check_field("frame_channel", want.channel, frame_channel_o);
          check_field("payload_byte", want.data, payload_byte_o);
          check_field("last_of_frame", 8'(want.last), 8'(last_of_frame_o));
          check_field("empty_frame", 8'(want.empty), 8'(empty_frame_o));
          beats_checked++;
        end
      end
      if (in_valid_i && in_ready_o) begin
        emits = advance_deframer(in_byte_i, pred);
        if (row_typed) begin
          if (cur_row.has_beat) expected_beats.push_back(cur_row.beat);
        end else if (emits) begin
          expected_beats.push_back(pred);
        end
      end
    end
  end

  // receiver: segments of steady, random and sparse ready, plus one long hold-off
  initial begin : receiver
    int unsigned mode;
    int unsigned seg;
    @(posedge rst_ni);
    forever begin
      if (hold_off_req) begin
        @(negedge clk_i);
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_off_req = 1'b0;
        hold_offs++;
      end else begin
        mode = $urandom_range(0, 2);
        seg = $urandom_range(1, 40);
        repeat (seg) begin
          @(negedge clk_i);
          case (mode)
            0: out_ready_i <= 1'b1;
            1: out_ready_i <= 1'($urandom_range(0, 1));
            default: out_ready_i <= ($urandom_range(0, 3) == 0);
          endcase
        end
      end
    end
  end

  // called at a falling edge, returns at the falling edge the beat goes out on
  task automatic pace_sender();
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
  endtask

  // called at a falling edge, returns at the rising edge that takes the beat
  task automatic offer_byte(input logic [7:0] b);
    in_valid_i <= 1'b1;
    in_byte_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic write_reg(input logic [clfd_pkg::CfgIdxW-1:0] idx,
                           input logic [clfd_pkg::CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      clfd_pkg::REG_EN0: channel_mask[63:0] = val;
      clfd_pkg::REG_EN1: channel_mask[127:64] = val;
      clfd_pkg::REG_EN2: channel_mask[191:128] = val;
      clfd_pkg::REG_EN3: channel_mask[255:192] = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic write_mask(input logic [clfd_pkg::MaskW-1:0] m);
    write_reg(clfd_pkg::REG_EN0, m[63:0]);
    write_reg(clfd_pkg::REG_EN1, m[127:64]);
    write_reg(clfd_pkg::REG_EN2, m[191:128]);
    write_reg(clfd_pkg::REG_EN3, m[255:192]);
  endtask

  // stop offering and let every pending beat come out
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic walk_rows(input int unsigned first, input int unsigned stop);
    for (int unsigned i = first; i < stop; i++) begin
      @(negedge clk_i);
      pace_sender();
      cur_row = directed_rows[i];
      row_typed = directed_rows[i].typed;
      offer_byte(directed_rows[i].din);
    end
  endtask

  task automatic run_random(input int unsigned quota);
    int unsigned counted;
    logic [7:0]  b;
    counted = 0;
    forever begin
      @(negedge clk_i);
      if (counted >= quota && parse_phase == SEEK_CHANNEL) break;
      pace_sender();
      b = pick_next_byte();
      if (parse_phase != SEEK_CHANNEL || channel_mask[b]) counted++;
      offer_byte(b);
    end
    in_valid_i <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  initial begin : stimulus
    logic [clfd_pkg::MaskW-1:0] m;
    directed_rows = '{
      // all channels off after reset
      '{8'h00, 1'b1, 1'b0, '0},
      '{8'hFF, 1'b1, 1'b0, '0},
      '{8'h80, 1'b1, 1'b0, '0},
      // disabled channel is dropped
      '{8'h03, 1'b1, 1'b0, '0},
      // channel 0, zero length gives one empty beat
      '{8'h00, 1'b1, 1'b0, '0},
      '{8'h00, 1'b1, 1'b0, '0},
      '{8'h00, 1'b1, 1'b0, '0},
      '{8'h00, 1'b1, 1'b0, '0},
      '{8'h00, 1'b1, 1'b1, '{channel: 8'h00, data: 8'h00, last: 1'b1, empty: 1'b1}},
      // channel 255, one payload byte of all ones
      '{8'hFF, 1'b1, 1'b0, '0},
      '{8'h01, 1'b1, 1'b0, '0},
      '{8'h00, 1'b1, 1'b0, '0},
      '{8'h00, 1'b1, 1'b0, '0},
      '{8'h00, 1'b1, 1'b0, '0},
      '{8'hFF, 1'b1, 1'b1, '{channel: 8'hFF, data: 8'hFF, last: 1'b1, empty: 1'b0}},
      // channel 128, two payload bytes
      '{8'h80, 1'b0, 1'b0, '0},
      '{8'h02, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b0, '0},
      '{8'hA5, 1'b0, 1'b0, '0}
    };

    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    walk_rows(0, NUM_RESET_ROWS);
    drain();
    write_reg(clfd_pkg::REG_EN0, 64'h0000_0000_0000_0021);
    write_reg(clfd_pkg::REG_EN1, 64'h8000_0000_0000_0001);
    write_reg(clfd_pkg::REG_EN2, 64'h0000_0000_0000_0001);
    write_reg(clfd_pkg::REG_EN3, 64'h8000_0000_0000_0000);
    write_reg(REG_SPARE, '1);
    write_reg(REG_TOP, '1);
    walk_rows(NUM_RESET_ROWS, NUM_ROWS);
    drain();
    row_typed = 1'b0;

    for (int unsigned p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: ;  // keep the sparse directed mask
        1: begin
          write_mask('1);
          hold_off_req = 1'b1;
        end
        2: begin
          for (int w = 0; w < clfd_pkg::MaskW / 32; w++) m[32 * w +: 32] = $urandom;
          m[$urandom_range(0, clfd_pkg::MaskW - 1)] = 1'b1;
          write_mask(m);
        end
        default: begin
          m = '0;
          m[$urandom_range(0, clfd_pkg::MaskW - 1)] = 1'b1;
          write_mask(m);
        end
      endcase
      run_random(ITEMS_PER_PHASE);
    end

    $display("covered %0d frames (%0d empty), %0d beats checked, %0d bytes skipped",
             frames_seen, empty_frames, beats_checked, bytes_skipped);
    $display("masks: reset, sparse, all on, random, single channel; %0d long hold-off",
             hold_offs);
    if (errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
